>>> rtl/ldu_pkg.sv
// ldu_pkg: shared types and constants for the linkage distance update unit
// no dependencies; imported by ldu_div and linkage_distance_update_unit

package ldu_pkg;

    // opcodes of an input beat
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_MERGE = 2'd2;

    // linkage methods
    localparam logic [2:0] LM_SINGLE   = 3'd0;
    localparam logic [2:0] LM_COMPLETE = 3'd1;
    localparam logic [2:0] LM_WPGMA    = 3'd2;
    localparam logic [2:0] LM_UPGMA    = 3'd3;
    localparam logic [2:0] LM_UPGMC    = 3'd4;
    localparam logic [2:0] LM_WPGMC    = 3'd5;

    // configuration register indexes
    localparam logic CFG_METHOD = 1'b0;
    localparam logic CFG_ACTIVE = 1'b1;

    // divider widths: dividend up to 14b x 32b signed, divisor up to n*n (n <= 254)
    localparam int DIV_W     = 46;
    localparam int DIVISOR_W = 16;

    typedef struct packed {
        logic                    start;
        logic signed [DIV_W-1:0] dividend;
        logic [DIVISOR_W-1:0]    divisor;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic signed [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

>>> rtl/linkage_distance_update_unit.sv
// linkage_distance_update_unit: top level, sequencer, distance ram and shared divider
// depends on ldu_pkg, ldu_ram, ldu_div

// Command-style block: a beat is taken when i_start is high and o_busy is low, and
// exactly one result beat follows on o_done, one cycle wide; the receiver cannot stall
// it. A write stores both mirror entries. A merge first divides ni*nj*d_ij by n*n once
// for upgmc, then visits each of the active rows, skipping the two merged rows; upgma
// and upgmc compute two quotients per row on the single bit-serial divider. The
// distance ram has one write port and one read port, and no reset; entries must be
// written before use.
module linkage_distance_update_unit #(
    parameter int MAX_CLUSTERS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_opcode,
    input  logic [5:0]  i_index_first,
    input  logic [5:0]  i_index_second,
    input  logic signed [31:0] i_distance_in,
    input  logic [6:0]  i_leaves_first,
    input  logic [6:0]  i_leaves_second,
    // result channel
    output logic        o_done,
    output logic signed [31:0] o_distance_out,
    output logic        o_status,
    // configuration
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data
);
    import ldu_pkg::*;

    localparam int IW = $clog2(MAX_CLUSTERS);
    localparam int AW = 2 * IW;
    localparam int LW = (IW + 1 > 7) ? IW + 1 : 7;

    typedef enum logic [16:0] {
        S_IDLE    = 17'b00000000000000001,
        S_WR2     = 17'b00000000000000010,
        S_RDWAIT  = 17'b00000000000000100,
        S_DIJ     = 17'b00000000000001000,
        S_PRE     = 17'b00000000000010000,
        S_TSTART  = 17'b00000000000100000,
        S_TWAIT   = 17'b00000000001000000,
        S_ROW     = 17'b00000000010000000,
        S_RDJ     = 17'b00000000100000000,
        S_GETJ    = 17'b00000001000000000,
        S_D1START = 17'b00000010000000000,
        S_D1WAIT  = 17'b00000100000000000,
        S_D2START = 17'b00001000000000000,
        S_D2WAIT  = 17'b00010000000000000,
        S_WRI     = 17'b00100000000000000,
        S_WRS     = 17'b01000000000000000,
        S_DONE    = 17'b10000000000000000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [2:0] r_method;
    logic [6:0] r_active;

    // per-item registers
    logic [IW-1:0]       r_i, r_j;
    logic [LW-1:0]       r_s, r_limit;
    logic [6:0]          r_ni, r_nj;
    logic [7:0]          r_n;
    logic [DIVISOR_W-1:0] r_nsq;
    logic [13:0]         r_nn;
    logic signed [31:0]  r_din, r_dij, r_dis, r_djs, r_dout;
    logic                r_status;
    logic signed [DIV_W-1:0] r_prod;
    logic signed [35:0]  r_term, r_acc;

    // ram port
    logic          w_ram_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [31:0]   w_wdata, w_rdata;

    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    // command decode
    logic          w_accept;
    logic [IW-1:0] w_ii, w_jj;
    logic [LW-1:0] w_limit;
    logic          w_bad;
    logic [6:0]    w_ni_fix, w_nj_fix;
    logic [IW-1:0] w_s;
    logic          w_skip, w_div_method;

    // new distance datapath
    logic signed [32:0] w_sum, w_sum_adj;
    logic signed [35:0] w_half, w_base, w_nd;
    logic signed [33:0] w_dij_adj;
    logic [31:0]        w_nd_sat;
    logic signed [39:0] w_prod_i, w_prod_j;

    assign w_accept = i_start && (r_state == S_IDLE);
    assign o_busy   = (r_state != S_IDLE);

    assign w_ii    = IW'(i_index_first);
    assign w_jj    = IW'(i_index_second);
    assign w_limit = (i_opcode == OP_MERGE && LW'(r_active) < LW'(MAX_CLUSTERS))
                   ? LW'(r_active) : LW'(MAX_CLUSTERS);
    assign w_bad   = (i_index_first == i_index_second)
                   || (LW'(i_index_first) >= w_limit)
                   || (LW'(i_index_second) >= w_limit);
    assign w_ni_fix = (i_leaves_first == '0) ? 7'd1 : i_leaves_first;
    assign w_nj_fix = (i_leaves_second == '0) ? 7'd1 : i_leaves_second;

    assign w_s          = r_s[IW-1:0];
    assign w_skip       = (w_s == r_i) || (w_s == r_j);
    assign w_div_method = (r_method == LM_UPGMA) || (r_method == LM_UPGMC);

    // (d_is + d_js) / 2 truncated toward zero
    assign w_sum     = 33'(r_dis) + 33'(r_djs);
    assign w_sum_adj = w_sum + $signed({32'b0, w_sum[32]});
    assign w_half    = 36'(w_sum_adj >>> 1);

    // d_ij / 4 truncated toward zero
    assign w_dij_adj = 34'(r_dij) + $signed({32'b0, r_dij[31], r_dij[31]});

    always_comb begin
        unique case (r_method)
            LM_SINGLE:   w_base = (r_dis < r_djs) ? 36'(r_dis) : 36'(r_djs);
            LM_COMPLETE: w_base = (r_dis > r_djs) ? 36'(r_dis) : 36'(r_djs);
            LM_UPGMA,
            LM_UPGMC:    w_base = r_acc;
            default:     w_base = w_half;
        endcase
    end

    // r_term holds d_ij/4 for wpgmc, ni*nj*d_ij/n^2 for upgmc, zero otherwise
    assign w_nd = w_base - r_term;

    // saturate to 32 bits when the upper bits are not a sign extension
    always_comb begin
        if (w_nd[35:31] == 5'b00000 || w_nd[35:31] == 5'b11111) begin
            w_nd_sat = w_nd[31:0];
        end else if (w_nd[35]) begin
            w_nd_sat = 32'h8000_0000;
        end else begin
            w_nd_sat = 32'h7fff_ffff;
        end
    end

    assign w_prod_i = 40'($signed({1'b0, r_ni})) * 40'(r_dis);
    assign w_prod_j = 40'($signed({1'b0, r_nj})) * 40'(r_djs);

    // ram addressing per state
    always_comb begin
        w_ram_we = 1'b0;
        w_waddr  = {r_i, w_s};
        w_wdata  = w_nd_sat;
        w_raddr  = {w_ii, w_jj};
        unique case (r_state)
            S_IDLE: begin
                w_ram_we = w_accept && (i_opcode == OP_WRITE) && !w_bad;
                w_waddr  = {w_ii, w_jj};
                w_wdata  = i_distance_in;
            end
            S_WR2: begin
                w_ram_we = 1'b1;
                w_waddr  = {r_j, r_i};
                w_wdata  = r_din;
            end
            S_ROW:   w_raddr = {r_i, w_s};
            S_RDJ:   w_raddr = {r_j, w_s};
            S_WRI:   w_ram_we = 1'b1;
            S_WRS: begin
                w_ram_we = 1'b1;
                w_waddr  = {w_s, r_i};
            end
            default: ;
        endcase
    end

    // divider requests: the upgmc term divides by n*n, row quotients by n
    always_comb begin
        w_div_req.start    = (r_state == S_TSTART) || (r_state == S_D1START)
                          || (r_state == S_D2START);
        w_div_req.dividend = r_prod;
        w_div_req.divisor  = (r_state == S_TSTART) ? r_nsq : DIVISOR_W'(r_n);
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_opcode != OP_WRITE && i_opcode != OP_READ && i_opcode != OP_MERGE) begin
                        n_state = S_DONE;
                    end else if (w_bad) begin
                        n_state = S_DONE;
                    end else if (i_opcode == OP_WRITE) begin
                        n_state = S_WR2;
                    end else if (i_opcode == OP_READ) begin
                        n_state = S_RDWAIT;
                    end else if (r_method > LM_WPGMC) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_DIJ;
                    end
                end
            end
            S_WR2:     n_state = S_DONE;
            S_RDWAIT:  n_state = S_DONE;
            S_DIJ:     n_state = S_PRE;
            S_PRE:     n_state = (r_method == LM_UPGMC) ? S_TSTART : S_ROW;
            S_TSTART:  n_state = S_TWAIT;
            S_TWAIT:   n_state = w_div_rsp.done ? S_ROW : S_TWAIT;
            S_ROW: begin
                if (r_s == r_limit) begin
                    n_state = S_DONE;
                end else if (!w_skip) begin
                    n_state = S_RDJ;
                end
            end
            S_RDJ:     n_state = S_GETJ;
            S_GETJ:    n_state = w_div_method ? S_D1START : S_WRI;
            S_D1START: n_state = S_D1WAIT;
            S_D1WAIT:  n_state = w_div_rsp.done ? S_D2START : S_D1WAIT;
            S_D2START: n_state = S_D2WAIT;
            S_D2WAIT:  n_state = w_div_rsp.done ? S_WRI : S_D2WAIT;
            S_WRI:     n_state = S_WRS;
            S_WRS:     n_state = S_ROW;
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_method <= LM_SINGLE;
            r_active <= 7'd64;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_METHOD: r_method <= i_cfg_data[2:0];
                    CFG_ACTIVE: r_active <= i_cfg_data;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_i      <= w_ii;
                r_j      <= w_jj;
                r_din    <= i_distance_in;
                r_limit  <= w_limit;
                r_ni     <= w_ni_fix;
                r_nj     <= w_nj_fix;
                r_dout   <= '0;
                r_status <= w_bad && (i_opcode == OP_WRITE || i_opcode == OP_READ
                                      || i_opcode == OP_MERGE);
            end
            S_RDWAIT: r_dout <= w_rdata;
            S_DIJ: begin
                r_dij <= w_rdata;
                r_nn  <= 14'(r_ni) * 14'(r_nj);
                r_n   <= 8'(r_ni) + 8'(r_nj);
                r_s   <= '0;
            end
            S_PRE: begin
                r_nsq  <= DIVISOR_W'(r_n) * DIVISOR_W'(r_n);
                r_prod <= DIV_W'($signed({1'b0, r_nn})) * DIV_W'(r_dij);
                r_term <= (r_method == LM_WPGMC) ? 36'(w_dij_adj >>> 2) : '0;
            end
            S_TWAIT: begin
                if (w_div_rsp.done) begin
                    r_term <= 36'(w_div_rsp.quotient);
                end
            end
            S_ROW: begin
                if (r_s != r_limit && w_skip) begin
                    r_s <= r_s + 1'b1;
                end
            end
            S_RDJ: r_dis <= w_rdata;
            S_GETJ: begin
                r_djs  <= w_rdata;
                r_prod <= DIV_W'(w_prod_i);
            end
            S_D1WAIT: begin
                if (w_div_rsp.done) begin
                    r_acc  <= 36'(w_div_rsp.quotient);
                    r_prod <= DIV_W'(w_prod_j);
                end
            end
            S_D2WAIT: begin
                if (w_div_rsp.done) begin
                    r_acc <= r_acc + 36'(w_div_rsp.quotient);
                end
            end
            S_WRS: r_s <= r_s + 1'b1;
            default: ;
        endcase
    end

    ldu_ram #(
        .WIDTH (32),
        .DEPTH (1 << AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ldu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // result beat
    assign o_done         = (r_state == S_DONE);
    assign o_distance_out = r_dout;
    assign o_status       = r_status;

    a_done_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_busy) else $error("result beat outside a command");
    a_err_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status) |-> (o_distance_out == '0))
        else $error("error beat carries data");
    a_accept_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_busy) else $error("command not taken");
    a_ram_write : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (r_state == S_IDLE || r_state == S_WR2 || r_state == S_WRI
                      || r_state == S_WRS)) else $error("stray ram write");

endmodule

>>> rtl/ldu_ram.sv
// ldu_ram: generic single-write, single-read ram with registered read data
// no dependencies

module ldu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/ldu_div.sv
// ldu_div: shared signed divider, restoring, one quotient bit per cycle
// truncates toward zero; depends on ldu_pkg

module ldu_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ldu_pkg::t_div_req i_req,
    output ldu_pkg::t_div_rsp o_rsp
);
    import ldu_pkg::*;

    localparam int CW = $clog2(DIV_W + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic                 r_neg;
    logic [DIVISOR_W-1:0] r_div;
    logic [DIVISOR_W:0]   r_rem;
    logic [DIV_W-1:0]     r_quo;

    logic [DIV_W-1:0]     w_abs;
    logic [DIVISOR_W:0]   w_trial;
    logic                 w_fit;

    assign w_abs   = i_req.dividend[DIV_W-1] ? DIV_W'(-i_req.dividend) : i_req.dividend;
    assign w_trial = {r_rem[DIVISOR_W-1:0], r_quo[DIV_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.dividend[DIV_W-1];
            r_div <= i_req.divisor;
            r_rem <= '0;
            r_quo <= w_abs;
        end else if (r_busy) begin
            r_rem <= w_fit ? (w_trial - {1'b0, r_div}) : w_trial;
            r_quo <= {r_quo[DIV_W-2:0], w_fit};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? -$signed(r_quo) : $signed(r_quo);

    a_start_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy) else $error("divider started while busy");
    a_start_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> r_busy) else $error("divider did not start");
    a_done_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while busy");

endmodule

>>> tb/ldu_checker.sv
// ldu_checker: watches the command, result and configuration ports of the
// linkage distance update unit, predicts every result beat and compares it
// depends on ldu_pkg
`timescale 1ns / 1ps

module ldu_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [1:0]         i_opcode,
    input  logic [5:0]         i_index_first,
    input  logic [5:0]         i_index_second,
    input  logic signed [31:0] i_distance_in,
    input  logic [6:0]         i_leaves_first,
    input  logic [6:0]         i_leaves_second,
    input  logic               i_done,
    input  logic signed [31:0] i_distance_out,
    input  logic               i_status,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_index,
    input  logic [6:0]         i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_merge_count
);
    import ldu_pkg::*;

    localparam int NCL = 64;

    typedef struct {
        logic signed [31:0] distance;
        logic               status;
    } t_answer;

    logic signed [31:0] dist_mat [NCL][NCL];
    logic [2:0]         method_q;
    logic [6:0]         active_q;
    t_answer            answers_q [$];

    initial begin
        o_fail_count  = 0;
        o_merge_count = 0;
        method_q      = LM_SINGLE;
        active_q      = 7'd64;
        for (int r = 0; r < NCL; r++)
            for (int c = 0; c < NCL; c++)
                dist_mat[r][c] = '0;
    end

    assign o_pending = answers_q.size();

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        o_fail_count++;
    endtask

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // lance-williams update of row and column ci against every other active row
    task automatic merge_rows(input int ci, input int cj, input int lim,
                              input longint ni, input longint nj);
        longint dij, dis, djs, nd, n;
        dij = dist_mat[ci][cj];
        n   = ni + nj;
        for (int s = 0; s < lim; s++) begin
            if (s != ci && s != cj) begin
                dis = dist_mat[ci][s];
                djs = dist_mat[cj][s];
                case (method_q)
                    LM_SINGLE:   nd = (dis < djs) ? dis : djs;
                    LM_COMPLETE: nd = (dis > djs) ? dis : djs;
                    LM_WPGMA:    nd = (dis + djs) / 2;
                    LM_UPGMA:    nd = ni * dis / n + nj * djs / n;
                    LM_UPGMC:    nd = ni * dis / n + nj * djs / n - ni * nj * dij / (n * n);
                    default:     nd = (dis + djs) / 2 - dij / 4;
                endcase
                dist_mat[ci][s] = clip32(nd);
                dist_mat[s][ci] = clip32(nd);
            end
        end
    endtask

    task automatic predict_beat();
        t_answer ans;
        int      lim;
        int      ci, cj;
        longint  ni, nj;
        ans.distance = '0;
        ans.status   = 1'b0;
        ci  = i_index_first;
        cj  = i_index_second;
        lim = NCL;
        if (i_opcode == OP_MERGE && active_q < NCL)
            lim = active_q;
        if (i_opcode == OP_WRITE || i_opcode == OP_READ || i_opcode == OP_MERGE) begin
            if (ci == cj || ci >= lim || cj >= lim) begin
                ans.status = 1'b1;
            end else if (i_opcode == OP_WRITE) begin
                dist_mat[ci][cj] = i_distance_in;
                dist_mat[cj][ci] = i_distance_in;
            end else if (i_opcode == OP_READ) begin
                ans.distance = dist_mat[ci][cj];
            end else if (method_q <= LM_WPGMC) begin
                // a leaf count of zero counts as one
                ni = (i_leaves_first == 0) ? 1 : i_leaves_first;
                nj = (i_leaves_second == 0) ? 1 : i_leaves_second;
                merge_rows(ci, cj, lim, ni, nj);
                o_merge_count++;
            end
        end
        answers_q.push_back(ans);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_done) begin
                if (answers_q.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    t_answer exp_a;
                    exp_a = answers_q.pop_front();
                    if (i_distance_out !== exp_a.distance)
                        report_mismatch($sformatf("distance_out %h, expected %h",
                                                  i_distance_out, exp_a.distance));
                    if (i_status !== exp_a.status)
                        report_mismatch($sformatf("status %b, expected %b",
                                                  i_status, exp_a.status));
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_METHOD)
                    method_q <= i_cfg_data[2:0];
                else
                    active_q <= i_cfg_data;
            end
            if (i_start && !i_busy)
                predict_beat();
        end
    end

endmodule

>>> tb/tb_linkage_distance_update_unit.sv
// tb_linkage_distance_update_unit: stimulus and verdict for the linkage distance
// update unit; depends on ldu_pkg, the block and ldu_checker
`timescale 1ns / 1ps

module tb_linkage_distance_update_unit;
    import ldu_pkg::*;

    // rows whose entries are all written; merges and reads stay on them
    localparam int FILL_ROWS = 8;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         opcode;
    logic [5:0]         idx_a;
    logic [5:0]         idx_b;
    logic signed [31:0] dist_in;
    logic [6:0]         leaves_a;
    logic [6:0]         leaves_b;
    logic               done;
    logic signed [31:0] dist_out;
    logic               status;
    logic               cfg_we;
    logic [0:0]         cfg_index;
    logic [6:0]         cfg_data;

    int fail_count;
    int pending;
    int merge_count;
    int beats_sent;
    int cfg_writes;
    bit calm;          // no idling in the last part of the run

    // 2 ns clock
    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    linkage_distance_update_unit u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_opcode       (opcode),
        .i_index_first  (idx_a),
        .i_index_second (idx_b),
        .i_distance_in  (dist_in),
        .i_leaves_first (leaves_a),
        .i_leaves_second(leaves_b),
        .o_done         (done),
        .o_distance_out (dist_out),
        .o_status       (status),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    ldu_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_opcode       (opcode),
        .i_index_first  (idx_a),
        .i_index_second (idx_b),
        .i_distance_in  (dist_in),
        .i_leaves_first (leaves_a),
        .i_leaves_second(leaves_b),
        .i_done         (done),
        .i_distance_out (dist_out),
        .i_status       (status),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_merge_count  (merge_count)
    );

    // one command beat; start stays high if the next beat follows at once
    task automatic send_beat(input logic [1:0] op, input int a, input int b,
                             input logic [31:0] d, input int na, input int nb);
        opcode   <= op;
        idx_a    <= a[5:0];
        idx_b    <= b[5:0];
        dist_in  <= d;
        leaves_a <= na[6:0];
        leaves_b <= nb[6:0];
        start    <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        beats_sent++;
        // random idle burst between beats
        if (!calm && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // config writes only with the block drained and settled
    task automatic write_cfg(input logic [0:0] idx, input int value);
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[6:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_writes++;
    endtask

    // random beat: mostly legal merges and reads on the filled rows, some noise
    task automatic random_beat(input int act);
        int pick, a, b, lim, inner;
        logic [1:0] op;
        pick  = $urandom_range(0, 99);
        lim   = (act > 64) ? 64 : ((act < 2) ? 2 : act);
        inner = (lim < FILL_ROWS) ? lim : FILL_ROWS;
        if (pick < 30)      op = OP_WRITE;
        else if (pick < 55) op = OP_READ;
        else if (pick < 95) op = OP_MERGE;
        else                op = 2'd3;
        a = $urandom_range(0, inner - 1);
        if (op == OP_MERGE) b = $urandom_range(0, inner - 1);
        else                b = $urandom_range(0, lim - 1);
        // occasional noise hits the error paths without touching unwritten rows
        if ($urandom_range(0, 9) == 0) begin
            if (op == OP_MERGE) b = (lim < 64) ? $urandom_range(lim, 63) : a;
            else                b = $urandom_range(0, 63);
        end
        if (op == OP_WRITE && $urandom_range(0, 9) == 0) a = $urandom_range(0, 63);
        send_beat(op, a, b, $urandom(), $urandom_range(0, 127), $urandom_range(0, 127));
    endtask

    initial begin
        int act, phase_len, meth;
        rst_n      = 1'b0;
        start      = 1'b0;
        opcode     = OP_WRITE;
        idx_a      = '0;
        idx_b      = '0;
        dist_in    = '0;
        leaves_a   = '0;
        leaves_b   = '0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_METHOD;
        cfg_data   = '0;
        calm       = 1'b0;
        beats_sent = 0;
        cfg_writes = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every pair that touches the first rows so no later read hits an
        // unwritten entry
        for (int r = 0; r < FILL_ROWS; r++)
            for (int c = r + 1; c < 64; c++)
                if ($urandom_range(0, 1))
                    send_beat(OP_WRITE, r, c, $urandom(), 0, 0);
                else
                    send_beat(OP_WRITE, c, r, $urandom(), 0, 0);

        // directed: extremes, error cases, every linkage on a small matrix
        write_cfg(CFG_ACTIVE, 4);
        send_beat(OP_WRITE, 0, 1, 32'h7fffffff, 0, 0);
        send_beat(OP_WRITE, 2, 0, 32'h80000000, 0, 0);
        send_beat(OP_WRITE, 1, 2, 32'h80000000, 0, 0);
        send_beat(OP_WRITE, 63, 62, 32'hffffffff, 0, 0);
        send_beat(OP_READ, 1, 0, 0, 0, 0);
        send_beat(OP_READ, 0, 2, 0, 0, 0);
        send_beat(OP_READ, 62, 63, 0, 0, 0);
        send_beat(OP_READ, 5, 5, 0, 0, 0);           // equal indices
        send_beat(OP_WRITE, 7, 7, 32'h12345678, 0, 0);
        send_beat(OP_MERGE, 0, 4, 0, 1, 1);          // beyond the active count
        send_beat(2'd3, 0, 1, 32'hdeadbeef, 3, 3);   // undefined opcode
        for (int m = 0; m < 8; m++) begin
            write_cfg(CFG_METHOD, m);
            // zero leaves count as one, full leaves stress the divides and saturation
            send_beat(OP_MERGE, 0, 1, 0, (m % 2) ? 127 : 0, (m % 2) ? 64 : 0);
            send_beat(OP_READ, 0, 3, 0, 0, 0);
        end

        // random phases over method and active count settings
        for (int p = 0; p < 16; p++) begin
            meth = (p < 8) ? p : $urandom_range(0, 7);
            case ($urandom_range(0, 9))
                0:       act = $urandom_range(0, 1);    // every merge errs
                1:       act = 64;
                2:       act = $urandom_range(65, 127); // capped at the matrix size
                default: act = $urandom_range(2, 12);
            endcase
            if (p == 15) act = 2;
            write_cfg(CFG_METHOD, meth);
            write_cfg(CFG_ACTIVE, act);
            phase_len = 25;
            calm = (p >= 14);
            for (int k = 0; k < phase_len; k++)
                random_beat(act);
        end
        start <= 1'b0;

        // drain, then let the block settle
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("covered %0d command beats, %0d merges applied, %0d config writes",
                 beats_sent, merge_count, cfg_writes);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #40_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/ldu_pkg.sv
rtl/ldu_ram.sv
rtl/ldu_div.sv
rtl/linkage_distance_update_unit.sv
tb/ldu_checker.sv
tb/tb_linkage_distance_update_unit.sv
